[rtl/core/fps_pkg.sv]
`default_nettype none

package fps_pkg;

  // field widths fixed by the item format
  localparam int OP_W    = 2;
  localparam int POS_W   = 11;
  localparam int DELTA_W = 32;
  localparam int SUM_W   = 64;

  // tree index: one bit above a position so the climb never overflows
  localparam int IDX_W   = POS_W + 1;

  localparam logic [POS_W-1:0] SIZE_RESET = 11'd1024;

  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_QRY_RD,
    ST_QRY_ACC,
    ST_CLR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic acc_sel;  // add onto the running sum instead of the delta
    logic zero;     // force a zero result for the clearing sweep
  } alu_ctl_t;

endpackage

`default_nettype wire

[rtl/core/fps_mem.sv]
`default_nettype none

module fps_mem #(
  parameter int WORDS = 1024,
  parameter int AW    = 10
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [AW-1:0]              waddr,
  input  wire logic [fps_pkg::SUM_W-1:0]  wdata,
  input  wire logic [AW-1:0]              raddr,
  output logic      [fps_pkg::SUM_W-1:0]  rd_data
);

  logic [fps_pkg::SUM_W-1:0] mem_r [WORDS];
  logic [fps_pkg::SUM_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[raddr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[rtl/core/fps_alu.sv]
`default_nettype none

module fps_alu (
  input  wire fps_pkg::alu_ctl_t                 ctl,
  input  wire logic        [fps_pkg::SUM_W-1:0]  acc,
  input  wire logic signed [fps_pkg::DELTA_W-1:0] delta,
  input  wire logic        [fps_pkg::SUM_W-1:0]  rd_data,
  input  wire logic        [fps_pkg::IDX_W-1:0]  k,
  output logic             [fps_pkg::SUM_W-1:0]  sum,
  output logic             [fps_pkg::IDX_W-1:0]  k_up,
  output logic             [fps_pkg::IDX_W-1:0]  k_down
);

  logic [fps_pkg::SUM_W-1:0] delta_ext;
  logic [fps_pkg::SUM_W-1:0] addend;
  logic [fps_pkg::IDX_W-1:0] low_bit;

  assign delta_ext = {{(fps_pkg::SUM_W - fps_pkg::DELTA_W){delta[fps_pkg::DELTA_W-1]}}, delta};
  assign addend    = ctl.acc_sel ? acc : delta_ext;

  // one shared wrapping adder serves both the update and the accumulate
  always_comb begin
    if (ctl.zero) begin
      sum = '0;
    end else begin
      sum = addend + rd_data;
    end
  end

  // lowest set bit of the tree index
  assign low_bit = k & (~k + fps_pkg::IDX_W'(1));
  assign k_up    = k + low_bit;
  assign k_down  = k - low_bit;

endmodule

`default_nettype wire

[rtl/core/fps_ctrl.sv]
`default_nettype none

module fps_ctrl #(
  parameter int USED = 1024,
  parameter int AW   = 10
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic        [fps_pkg::POS_W-1:0]  cfg_wr_data,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic        [fps_pkg::OP_W-1:0]   in_op,
  input  wire logic        [fps_pkg::POS_W-1:0]  in_pos,
  input  wire logic signed [fps_pkg::DELTA_W-1:0] in_delta,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic             [fps_pkg::SUM_W-1:0]  out_sum,
  output logic                                   out_status,
  output logic                                   mem_we,
  output logic             [AW-1:0]              mem_waddr,
  output logic             [AW-1:0]              mem_raddr,
  output fps_pkg::alu_ctl_t                      alu_ctl,
  output logic             [fps_pkg::SUM_W-1:0]  alu_acc,
  output logic signed      [fps_pkg::DELTA_W-1:0] alu_delta,
  output logic             [fps_pkg::IDX_W-1:0]  alu_k,
  input  wire logic        [fps_pkg::SUM_W-1:0]  alu_sum,
  input  wire logic        [fps_pkg::IDX_W-1:0]  alu_k_up,
  input  wire logic        [fps_pkg::IDX_W-1:0]  alu_k_down
);

  localparam logic [AW-1:0] CLR_LAST = AW'(USED - 1);

  fps_pkg::state_t state_r, state_nxt;

  logic [fps_pkg::POS_W-1:0]   size_r;
  logic [AW-1:0]               clr_r, clr_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [fps_pkg::IDX_W-1:0]   k_r, k_nxt;
  logic [fps_pkg::SUM_W-1:0]   acc_r, acc_nxt;
  logic signed [fps_pkg::DELTA_W-1:0] delta_r, delta_nxt;
  logic                        status_r, status_nxt;
  logic [fps_pkg::SUM_W-1:0]   out_sum_r, out_sum_nxt;
  logic                        out_status_r, out_status_nxt;

  logic [fps_pkg::IDX_W-1:0]   n_eff;
  logic [fps_pkg::IDX_W-1:0]   pos_ext;
  logic [fps_pkg::IDX_W-1:0]   k_m1;
  logic                        add_bad;
  logic                        out_load;
  logic                        sweeping;

  // size register saturated into 1..USED
  always_comb begin
    if (size_r == '0) begin
      n_eff = fps_pkg::IDX_W'(1);
    end else if ({1'b0, size_r} > fps_pkg::IDX_W'(USED)) begin
      n_eff = fps_pkg::IDX_W'(USED);
    end else begin
      n_eff = {1'b0, size_r};
    end
  end

  assign pos_ext  = {1'b0, in_pos};
  assign add_bad  = (pos_ext == '0) || (pos_ext > n_eff);
  assign k_m1     = k_r - fps_pkg::IDX_W'(1);
  assign out_load = (state_r == fps_pkg::ST_DONE) && (!out_valid_r || out_tready);
  assign sweeping = (state_r == fps_pkg::ST_INIT) || (state_r == fps_pkg::ST_CLR);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fps_pkg::ST_INIT: begin
        if (clr_r == CLR_LAST) state_nxt = fps_pkg::ST_IDLE;
      end
      fps_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          case (in_op)
            fps_pkg::OP_ADD:   state_nxt = add_bad ? fps_pkg::ST_DONE : fps_pkg::ST_ADD_RD;
            fps_pkg::OP_QUERY: state_nxt = (pos_ext == '0) ? fps_pkg::ST_DONE
                                                           : fps_pkg::ST_QRY_RD;
            fps_pkg::OP_CLEAR: state_nxt = fps_pkg::ST_CLR;
            default:           state_nxt = fps_pkg::ST_DONE;
          endcase
        end
      end
      fps_pkg::ST_ADD_RD:  state_nxt = fps_pkg::ST_ADD_WR;
      fps_pkg::ST_ADD_WR: begin
        state_nxt = (alu_k_up <= n_eff) ? fps_pkg::ST_ADD_RD : fps_pkg::ST_DONE;
      end
      fps_pkg::ST_QRY_RD:  state_nxt = fps_pkg::ST_QRY_ACC;
      fps_pkg::ST_QRY_ACC: begin
        state_nxt = (alu_k_down == '0) ? fps_pkg::ST_DONE : fps_pkg::ST_QRY_RD;
      end
      fps_pkg::ST_CLR: begin
        if (clr_r == CLR_LAST) state_nxt = fps_pkg::ST_DONE;
      end
      fps_pkg::ST_DONE: begin
        if (out_load) state_nxt = fps_pkg::ST_IDLE;
      end
      default: state_nxt = fps_pkg::ST_INIT;
    endcase
  end

  // outputs per state
  always_comb begin
    in_tready       = 1'b0;
    mem_we          = 1'b0;
    alu_ctl.acc_sel = 1'b0;
    alu_ctl.zero    = 1'b0;
    case (state_r)
      fps_pkg::ST_IDLE:    in_tready = 1'b1;
      fps_pkg::ST_ADD_WR:  mem_we = 1'b1;
      fps_pkg::ST_QRY_ACC: alu_ctl.acc_sel = 1'b1;
      fps_pkg::ST_INIT, fps_pkg::ST_CLR: begin
        mem_we       = 1'b1;
        alu_ctl.zero = 1'b1;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  assign mem_waddr  = sweeping ? clr_r : k_m1[AW-1:0];
  assign mem_raddr  = k_m1[AW-1:0];
  assign alu_acc    = acc_r;
  assign alu_delta  = delta_r;
  assign alu_k      = k_r;
  assign out_tvalid = out_valid_r;
  assign out_sum    = out_sum_r;
  assign out_status = out_status_r;

  // datapath next values
  always_comb begin
    clr_nxt        = clr_r;
    k_nxt          = k_r;
    acc_nxt        = acc_r;
    delta_nxt      = delta_r;
    status_nxt     = status_r;
    out_sum_nxt    = out_sum_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r;

    if (sweeping) begin
      clr_nxt = (clr_r == CLR_LAST) ? '0 : clr_r + AW'(1);
    end

    if (state_r == fps_pkg::ST_IDLE && in_tvalid) begin
      acc_nxt    = '0;
      delta_nxt  = in_delta;
      status_nxt = (in_op == fps_pkg::OP_ADD) && add_bad;
      if (in_op == fps_pkg::OP_QUERY && pos_ext > n_eff) begin
        k_nxt = n_eff;
      end else begin
        k_nxt = pos_ext;
      end
    end

    if (state_r == fps_pkg::ST_ADD_WR) begin
      k_nxt = alu_k_up;
    end

    if (state_r == fps_pkg::ST_QRY_ACC) begin
      k_nxt   = alu_k_down;
      acc_nxt = alu_sum;
    end

    if (out_load) begin
      out_valid_nxt  = 1'b1;
      out_sum_nxt    = acc_r;
      out_status_nxt = status_r;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fps_pkg::ST_INIT;
      clr_r       <= '0;
      size_r      <= fps_pkg::SIZE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        size_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r          <= k_nxt;
    acc_r        <= acc_nxt;
    delta_r      <= delta_nxt;
    status_r     <= status_nxt;
    out_sum_r    <= out_sum_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

`default_nettype wire

[rtl/core/fenwick_prefix_sum_engine.sv]
`default_nettype none

// Binary indexed tree of wrapping signed 64-bit sums over positions 1..n, where n is
// the size register saturated into 1..min(DEPTH, 2047). One word is taken at a time;
// the next is accepted once the result of the current one is in the output register.
// The tree sits in one memory with a registered read, and every node visited is read
// and then added onto (and for an update written back) through one shared 64-bit
// adder: an add climbs up to log2(n) + 1 nodes, a query walks down the set bits of
// the clamped position, a clear sweeps all min(DEPTH, 2047) words of the memory, and
// a rejected add, a zero query or an unknown operation goes straight to the result.
// After reset the block runs a clearing pass over min(DEPTH, 2047) words (1024 by
// default) with in_tready low; size writes are taken throughout.

module fenwick_prefix_sum_engine #(
  parameter int DEPTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration: size_in_use
  input  wire logic        cfg_wr_en,
  input  wire logic [10:0] cfg_wr_data,
  // input words
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // position[10:0], delta[42:11], zero fill
  input  wire logic [1:0]  in_tuser,   // operation[1:0]
  // result words
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // sum[63:0]
  output logic [0:0]       out_tuser   // status[0]
);

  localparam int POS_MAX = (1 << fps_pkg::POS_W) - 1;
  localparam int USED    = (DEPTH < POS_MAX) ? DEPTH : POS_MAX;
  localparam int AW      = (USED > 1) ? $clog2(USED) : 1;

  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [AW-1:0]               mem_raddr;
  logic [fps_pkg::SUM_W-1:0]   mem_rd_data;
  fps_pkg::alu_ctl_t           alu_ctl;
  logic [fps_pkg::SUM_W-1:0]   alu_acc;
  logic signed [fps_pkg::DELTA_W-1:0] alu_delta;
  logic [fps_pkg::IDX_W-1:0]   alu_k;
  logic [fps_pkg::SUM_W-1:0]   alu_sum;
  logic [fps_pkg::IDX_W-1:0]   alu_k_up;
  logic [fps_pkg::IDX_W-1:0]   alu_k_down;
  logic                        status_bit;

  fps_ctrl #(
    .USED (USED),
    .AW   (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_op       (in_tuser),
    .in_pos      (in_tdata[10:0]),
    .in_delta    (signed'(in_tdata[42:11])),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_sum     (out_tdata),
    .out_status  (status_bit),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_raddr   (mem_raddr),
    .alu_ctl     (alu_ctl),
    .alu_acc     (alu_acc),
    .alu_delta   (alu_delta),
    .alu_k       (alu_k),
    .alu_sum     (alu_sum),
    .alu_k_up    (alu_k_up),
    .alu_k_down  (alu_k_down)
  );

  fps_alu u_alu (
    .ctl     (alu_ctl),
    .acc     (alu_acc),
    .delta   (alu_delta),
    .rd_data (mem_rd_data),
    .k       (alu_k),
    .sum     (alu_sum),
    .k_up    (alu_k_up),
    .k_down  (alu_k_down)
  );

  fps_mem #(
    .WORDS (USED),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (alu_sum),
    .raddr   (mem_raddr),
    .rd_data (mem_rd_data)
  );

  assign out_tuser = status_bit;

  // one word in flight: busy right after a word is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("accepted a word while the previous one was in progress");

  // tree is never written while the block is taking words
  a_no_write_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !in_tready)
    else $error("tree write while idle");

  // the clearing pass holds off input right after reset
  a_init_sweep: assert property (@(posedge clk)
    $rose(rst_n) |-> !in_tready)
    else $error("ready before the clearing pass");

  // a rejected add never carries a sum
  a_status_zero_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == '0))
    else $error("flagged result with a nonzero sum");

endmodule

`default_nettype wire
